### rtl/swpm_pkg.sv
// Shared types, constants and register codes of the waterfall pixel mapper.
package swpm_pkg;

   localparam int WidthCfgW  = 13;
   localparam int LengthCfgW = 14;
   localparam int BinW       = 16;
   localparam int PixIdxW    = 12;
   localparam int HueW       = 9;
   localparam int SatW       = 8;
   localparam int AccW       = 28;
   localparam int BinCntW    = 14;

   localparam int DefMaxWidth    = 4096;
   localparam int DefMaxSpectrum = 8192;
   localparam int ResetWidth     = 256;
   localparam int ResetLength    = 512;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 14;

   localparam int QueueDepth = 4;

   localparam logic signed [BinW-1:0] PeakFloor = 16'sh8000;

   // hue = 299 - round((peak/256 + 114) * 359 / 2400), divide by 614400 = 8192 * 75
   localparam int HueOffW       = 18;
   localparam int HueProdW      = 27;
   localparam int HueQuotInW    = 12;
   localparam int HueQuotW      = 24;
   localparam int HueOffsetQ    = 29184;
   localparam int HueScale      = 359;
   localparam int HueHalf       = 307200;
   localparam int HueShift      = 13;
   localparam int HueBias       = 150;
   localparam int HueRecip      = 3496;
   localparam int HueRecipShift = 18;
   localparam int HueTop        = 301;
   localparam int HueMax        = 359;

   // saturation = floor((359 - hue) * 255 / 359)
   localparam int SatProdW      = 17;
   localparam int SatQuotW      = 34;
   localparam int SatScale      = 255;
   localparam int SatRecip      = 93467;
   localparam int SatRecipShift = 25;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DISPLAY_WIDTH   = 2'd0,
      CSR_SPECTRUM_LENGTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [BinW-1:0] bin_db;
      logic                   last_bin;
   } req_type;

   typedef struct packed {
      logic [PixIdxW-1:0] pixel_index;
      logic [HueW-1:0]    hue;
      logic [SatW-1:0]    saturation;
      logic               last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [PixIdxW-1:0]     pixel_index;
      logic signed [BinW-1:0] peak;
      logic                   last_pixel;
   } pix_type;

endpackage

### rtl/swpm_front.sv
// Front end: configuration registers, bin-to-pixel decimation and max-hold.
module swpm_front
   import swpm_pkg::*;
#(
   parameter int MAX_WIDTH    = DefMaxWidth,
   parameter int MAX_SPECTRUM = DefMaxSpectrum
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output logic                push,
   output pix_type             push_data,
   input  logic                queue_full
);

   localparam int ResetEffW   = (ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth;
   localparam int ResetEffLen = (ResetLength > MAX_SPECTRUM) ? MAX_SPECTRUM : ResetLength;
   localparam int ResetNe     = (ResetEffLen > 2 * ResetEffW) ? ResetEffLen : 2 * ResetEffW;

   logic [WidthCfgW-1:0]   width_ff, width_in;
   logic [LengthCfgW-1:0]  length_ff, length_in;
   logic [WidthCfgW-1:0]   pixel_cnt_ff, pixel_cnt_in;
   logic [BinCntW-1:0]     bin_cnt_ff, bin_cnt_in;
   logic signed [BinW-1:0] peak_ff, peak_in;
   logic [AccW-1:0]        edge_acc_ff, edge_acc_in;
   logic [AccW-1:0]        bin_acc_ff, bin_acc_in;

   logic                   cfg_hit;
   logic                   accept;
   logic                   restart;
   logic                   active;
   logic                   close;
   logic signed [BinW-1:0] peak_max;
   logic [WidthCfgW-1:0]   eff_w, eff_w_in;
   logic [LengthCfgW-1:0]  eff_len, eff_len_in;
   logic [LengthCfgW-1:0]  two_w, two_w_in;
   logic [LengthCfgW-1:0]  ne, ne_in;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      width_in  = width_ff;
      length_in = length_ff;
      cfg_hit   = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH: begin
               width_in = csr_wdata[WidthCfgW-1:0];
               cfg_hit  = 1'b1;
            end
            CSR_SPECTRUM_LENGTH: begin
               length_in = csr_wdata[LengthCfgW-1:0];
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      eff_w      = (32'(width_ff) > MAX_WIDTH) ? WidthCfgW'(MAX_WIDTH) : width_ff;
      eff_w_in   = (32'(width_in) > MAX_WIDTH) ? WidthCfgW'(MAX_WIDTH) : width_in;
      eff_len    = (32'(length_ff) > MAX_SPECTRUM) ? LengthCfgW'(MAX_SPECTRUM) : length_ff;
      eff_len_in = (32'(length_in) > MAX_SPECTRUM) ? LengthCfgW'(MAX_SPECTRUM) : length_in;
      two_w      = {eff_w, 1'b0};
      two_w_in   = {eff_w_in, 1'b0};
      ne         = (eff_len > two_w) ? eff_len : two_w;
      ne_in      = (eff_len_in > two_w_in) ? eff_len_in : two_w_in;
   end

   always_comb begin
      active   = (eff_w != '0) && (bin_cnt_ff < eff_len) && (pixel_cnt_ff < eff_w);
      close    = active && (edge_acc_ff < bin_acc_ff);
      peak_max = (req_data.bin_db > peak_ff) ? req_data.bin_db : peak_ff;
      restart  = cfg_hit || (accept && req_data.last_bin);

      push                  = accept && close;
      push_data.pixel_index = pixel_cnt_ff[PixIdxW-1:0];
      push_data.peak        = peak_max;
      push_data.last_pixel  = (pixel_cnt_ff + WidthCfgW'(1)) == eff_w;

      pixel_cnt_in = pixel_cnt_ff;
      bin_cnt_in   = bin_cnt_ff;
      peak_in      = peak_ff;
      edge_acc_in  = edge_acc_ff;
      bin_acc_in   = bin_acc_ff;
      if (accept) begin
         if (active) begin
            peak_in    = close ? PeakFloor : peak_max;
            bin_acc_in = bin_acc_ff + AccW'(two_w);
            if (close) begin
               pixel_cnt_in = pixel_cnt_ff + WidthCfgW'(1);
               edge_acc_in  = edge_acc_ff + AccW'(ne);
            end
         end
         if (bin_cnt_ff != '1) begin
            bin_cnt_in = bin_cnt_ff + BinCntW'(1);
         end
      end
      if (restart) begin
         pixel_cnt_in = '0;
         bin_cnt_in   = '0;
         peak_in      = PeakFloor;
         edge_acc_in  = AccW'(ne_in);
         bin_acc_in   = AccW'({eff_w_in, 2'b00});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WidthCfgW'(ResetWidth);
         length_ff    <= LengthCfgW'(ResetLength);
         pixel_cnt_ff <= '0;
         bin_cnt_ff   <= '0;
         peak_ff      <= PeakFloor;
         edge_acc_ff  <= AccW'(ResetNe);
         bin_acc_ff   <= AccW'(4 * ResetEffW);
      end else begin
         width_ff     <= width_in;
         length_ff    <= length_in;
         pixel_cnt_ff <= pixel_cnt_in;
         bin_cnt_ff   <= bin_cnt_in;
         peak_ff      <= peak_in;
         edge_acc_ff  <= edge_acc_in;
         bin_acc_ff   <= bin_acc_in;
      end
   end

endmodule

### rtl/swpm_queue.sv
// Small FIFO of closed pixels between the front end and the color back end.
module swpm_queue
   import swpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pix_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output pix_type pop_data
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   pix_type             mem_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_pop;

   assign full     = count_ff == CntW'(QueueDepth);
   assign valid    = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/swpm_back.sv
// Back end: pipelined peak-to-hue and hue-to-saturation mapping with output register.
module swpm_back
   import swpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  pix_type q_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                       advance;
   logic signed [BinW-1:0]     peak;
   logic signed [HueOffW-1:0]  off;
   logic signed [HueProdW-1:0] prod_in;
   logic signed [HueProdW-1:0] rounded;
   logic [HueQuotInW-1:0]      quot_in;
   logic [HueQuotW-1:0]        hq_in;
   logic [HueW-1:0]            hue_in;
   logic [SatProdW-1:0]        d_in;
   logic [SatQuotW-1:0]        sq_in;

   logic                       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                       out_valid_ff;
   logic [PixIdxW-1:0]         s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic                       s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic signed [HueProdW-1:0] s1_prod_ff;
   logic [HueQuotW-1:0]        s2_hq_ff;
   logic [HueW-1:0]            s3_hue_ff, s4_hue_ff;
   logic [SatProdW-1:0]        s3_d_ff;
   logic [SatQuotW-1:0]        s4_sq_ff;
   rsp_type                    out_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign pop       = advance && q_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      peak    = q_data.peak;
      off     = HueOffW'(peak) + HueOffW'(HueOffsetQ);
      prod_in = HueProdW'(off) * HueProdW'(HueScale);

      rounded = (s1_prod_ff + HueProdW'(HueHalf)) >>> HueShift;
      quot_in = HueQuotInW'(rounded + HueProdW'(HueBias));
      hq_in   = HueQuotW'(quot_in) * HueQuotW'(HueRecip);

      hue_in  = HueW'(HueTop) - HueW'(s2_hq_ff >> HueRecipShift);
      d_in    = SatProdW'(HueW'(HueMax) - hue_in) * SatProdW'(SatScale);

      sq_in   = SatQuotW'(s3_d_ff) * SatQuotW'(SatRecip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff  <= q_data.pixel_index;
         s1_last_ff <= q_data.last_pixel;
         s1_prod_ff <= prod_in;

         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;
         s2_hq_ff   <= hq_in;

         s3_idx_ff  <= s2_idx_ff;
         s3_last_ff <= s2_last_ff;
         s3_hue_ff  <= hue_in;
         s3_d_ff    <= d_in;

         s4_idx_ff  <= s3_idx_ff;
         s4_last_ff <= s3_last_ff;
         s4_hue_ff  <= s3_hue_ff;
         s4_sq_ff   <= sq_in;

         out_ff.pixel_index <= s4_idx_ff;
         out_ff.hue         <= s4_hue_ff;
         out_ff.saturation  <= SatW'(s4_sq_ff >> SatRecipShift);
         out_ff.last_pixel  <= s4_last_ff;
      end
   end

endmodule

### rtl/spectrum_waterfall_pixel_mapper.sv
// Top level of the spectrum waterfall pixel mapper.
//
// req channel: one spectrum bin per request (signed Q8.8 dB level and a frame-end flag).
// rsp channel: one colored pixel (column, hue, saturation, row-end flag) for each bin
//   that closes a pixel; other bins give no pixel.
// csr channel: display width (index 0) and spectrum length (index 1); a write also
//   restarts the row. Write only while the block is idle. csr_ready is always high.
// Throughput: one request per cycle, sustained, as long as rsp is taken every cycle.
// A pixel reaches rsp through the queue (written on the edge that accepts the request that
//   closes it), four mapping stages and the output register.
// The front end keeps up at one bin per cycle while the queue is not full; the back end is a
//   five-register pipeline with one multiplier in each of its four mapping stages.
// When rsp_stall is high and a pixel is on rsp, the back pipeline holds; the four-entry queue absorbs
//   closed pixels, and req_stall rises once it is full.
// Reset (synchronous) restores width 256 and length 512, empties the queue and
//   pipeline, and starts a new row.
module spectrum_waterfall_pixel_mapper
   import swpm_pkg::*;
#(
   parameter int MAX_WIDTH    = DefMaxWidth,
   parameter int MAX_SPECTRUM = DefMaxSpectrum
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic    q_push;
   pix_type q_push_data;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   pix_type q_pop_data;

   swpm_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_SPECTRUM(MAX_SPECTRUM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (q_push),
      .push_data (q_push_data),
      .queue_full(q_full)
   );

   swpm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_data (q_pop_data)
   );

   swpm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_pop_data),
      .pop      (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("pixel pushed into full queue");

   a_pop_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !q_valid))
      else $error("output or queue not empty after reset");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue <= HueW'(HueMax)))
      else $error("hue out of range");
`endif

endmodule
